@@ hdl/ist_pkg.sv @@
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and codes of the integer set table: operation codes, result
// status codes and the control group that drives the min/max tracker.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int VALUE_W    = 32;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int POSITION_W = 6;
  localparam int SIZE_W     = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_PRESENT   = 3'd5,
    ST_ABSENT    = 3'd6
  } status_t;

  typedef struct packed {
    logic clear;   // restart with an empty set (both extremes 0)
    logic sample;  // fold the presented entry into the extremes
    logic first;   // presented entry is the first one of the scan
  } ext_ctl_t;

endpackage

@@ hdl/ist_req_if.sv @@
// ----------------------------------------------------------------------------
// ist_req_if
// Request channel of the integer set table: one operation and its value.
// ----------------------------------------------------------------------------
interface ist_req_if;
  import ist_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

@@ hdl/ist_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ist_rsp_if
// Response channel of the integer set table: status, position and the
// summary of the set after the operation.
// ----------------------------------------------------------------------------
interface ist_rsp_if;
  import ist_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [POSITION_W-1:0]      position;
  logic [SIZE_W-1:0]          size;
  logic                       is_empty;
  logic signed [VALUE_W-1:0]  smallest;
  logic signed [VALUE_W-1:0]  largest;

  modport source (output valid, output status, output position, output size,
                  output is_empty, output smallest, output largest, input ready);
  modport sink   (input valid, input status, input position, input size,
                  input is_empty, input smallest, input largest, output ready);
endinterface

@@ hdl/ist_extremes.sv @@
// ----------------------------------------------------------------------------
// ist_extremes
// Running minimum and maximum over the entries streamed out of the table
// during the final scan of an operation.
// ----------------------------------------------------------------------------
module ist_extremes (
  input  logic                              clk,
  input  ist_pkg::ext_ctl_t                 ctl,
  input  logic signed [ist_pkg::VALUE_W-1:0] data,
  output logic signed [ist_pkg::VALUE_W-1:0] lo,
  output logic signed [ist_pkg::VALUE_W-1:0] hi
);
  import ist_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      lo <= '0;
      hi <= '0;
    end else if (ctl.sample) begin
      if (ctl.first || data < lo) begin
        lo <= data;
      end
      if (ctl.first || data > hi) begin
        hi <= data;
      end
    end
  end

endmodule

@@ hdl/integer_set_table.sv @@
// ----------------------------------------------------------------------------
// integer_set_table
// Set of distinct signed 32-bit integers kept in an unordered array.
// ----------------------------------------------------------------------------
// Usage: each request on req carries an op (insert, remove, lookup; the
// unused code acts as lookup) and a value. One response per request comes
// out on rsp with the status, the matched position, the size after the
// operation, an empty flag, and the smallest and largest entries (0 when
// the set is empty).
// The table is one single-port-write, single-port-read memory with a
// registered read, walked by one address counter. A request runs a search
// pass, a decision step (S_ACT), for a remove a shift pass over the entries
// above the match, and a min/max pass, then loads the response register.
// req.ready is high only between requests, so the next request is taken
// only once the last has reached the response register. A finished
// response waits in its register while rsp.ready is low; the next request
// may be taken meanwhile, and its response is held back until the register
// is free.
// Synchronous reset empties the set; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module integer_set_table #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  ist_req_if.sink   req,
  ist_rsp_if.source rsp
);
  import ist_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ACT,
    S_SHIFT,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          ptr;
  logic [OP_W-1:0]           op_q;
  logic signed [VALUE_W-1:0] value_q;
  logic                      hit;
  logic [IDX_W-1:0]          hit_idx;
  status_t                   status_q;
  logic [IDX_W-1:0]          pos_q;

  logic                      rd_valid;
  logic [IDX_W-1:0]          rd_idx;
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] mem [CAPACITY];

  logic                      issue;
  logic                      match;
  logic                      drained;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;

  ext_ctl_t                  ext_ctl;
  logic signed [VALUE_W-1:0] ext_lo;
  logic signed [VALUE_W-1:0] ext_hi;

  logic                      out_valid;
  logic [STATUS_W-1:0]       out_status;
  logic [POSITION_W-1:0]     out_position;
  logic [SIZE_W-1:0]         out_size;
  logic                      out_empty;
  logic signed [VALUE_W-1:0] out_lo;
  logic signed [VALUE_W-1:0] out_hi;

  // One read per cycle streams the live entries to the compare, shift and min/max logic.
  assign issue   = (state == S_SEARCH || state == S_SHIFT || state == S_SCAN) &&
                   (ptr < count);
  assign match   = rd_valid && (rd_data == value_q);
  assign drained = (ptr >= count) && !rd_valid;

  // Writes come from an append in the decision cycle or from the shift pass,
  // which moves each entry read one slot down.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx - IDX_W'(1);
    mem_wdata = rd_data;
    if (state == S_ACT) begin
      mem_waddr = count[IDX_W-1:0];
      mem_wdata = value_q;
      mem_we    = (op_q == OP_INSERT) && !hit && (count != CAP_CNT);
    end else if (state == S_SHIFT) begin
      mem_we    = rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= mem[ptr[IDX_W-1:0]];
    end
  end

  assign ext_ctl.clear  = (state == S_ACT);
  assign ext_ctl.sample = (state == S_SCAN) && rd_valid;
  assign ext_ctl.first  = (rd_idx == '0);

  ist_extremes u_extremes (
    .clk  (clk),
    .ctl  (ext_ctl),
    .data (rd_data),
    .lo   (ext_lo),
    .hi   (ext_hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        rd_idx <= ptr[IDX_W-1:0];
        ptr    <= ptr + CNT_W'(1);
      end
      // A response taken while the next one is loaded stays valid below.
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q    <= req.op;
            value_q <= req.value;
            hit     <= 1'b0;
            hit_idx <= '0;
            ptr     <= '0;
            state   <= (count == '0) ? S_ACT : S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (match) begin
            hit     <= 1'b1;
            hit_idx <= rd_idx;
            state   <= S_ACT;
          end else if (drained) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          ptr   <= '0;
          pos_q <= '0;
          state <= S_SCAN;
          unique case (op_q)
            OP_INSERT: begin
              if (hit) begin
                status_q <= ST_DUPLICATE;
              end else if (count == CAP_CNT) begin
                status_q <= ST_FULL;
              end else begin
                status_q <= ST_INSERTED;
                count    <= count + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                status_q <= ST_REMOVED;
                pos_q    <= hit_idx;
                ptr      <= CNT_W'(hit_idx) + CNT_W'(1);
                state    <= S_SHIFT;
              end else begin
                status_q <= ST_NOT_FOUND;
              end
            end
            default: begin
              pos_q    <= hit_idx;
              status_q <= hit ? ST_PRESENT : ST_ABSENT;
            end
          endcase
        end
        S_SHIFT: begin
          if (drained) begin
            count <= count - CNT_W'(1);
            ptr   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (drained) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid    <= 1'b1;
            out_status   <= status_q;
            out_position <= POSITION_W'(pos_q);
            out_size     <= SIZE_W'(count);
            out_empty    <= (count == '0);
            out_lo       <= ext_lo;
            out_hi       <= ext_hi;
            state        <= S_IDLE;
          end else if (out_valid && rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.position = out_position;
  assign rsp.size     = out_size;
  assign rsp.is_empty = out_empty;
  assign rsp.smallest = out_lo;
  assign rsp.largest  = out_hi;

endmodule

@@ tb/tb_integer_set_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_set_table
// Self-checking bench for the integer set table. A short table of requests
// covers the field extremes, every operation, the alias of the spare op code
// and the empty set. Random phases then fill the table to capacity, drain it
// and mix operations. Every response is checked against a fixed result from
// the table or a queue-based model of the set. Both channels idle at random,
// and once the response side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_integer_set_table;
  import ist_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int TOTAL_ITEMS = 1750;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 3 * CAPACITY + 16;

  // The spare op code is decoded as a lookup by the block.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] MINUS_1 = 32'shFFFF_FFFF;
  localparam logic signed [VALUE_W-1:0] ALT_0101 = 32'sh5555_5555;
  localparam logic signed [VALUE_W-1:0] ALT_1010 = 32'shAAAA_AAAA;

  typedef struct {
    status_t                   status;
    logic [POSITION_W-1:0]     position;
    logic [SIZE_W-1:0]         size;
    logic                      is_empty;
    logic signed [VALUE_W-1:0] smallest;
    logic signed [VALUE_W-1:0] largest;
  } set_result_t;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    bit                        fixed_result;
    set_result_t               result;
  } directed_row_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  localparam set_result_t FROM_MODEL = '{ST_INSERTED, 6'd0, 7'd0, 1'b0, 32'sd0, 32'sd0};

  localparam int N_DIRECTED = 24;
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{OP_LOOKUP, 32'sd0,   1'b1, '{ST_ABSENT,    6'd0, 7'd0, 1'b1, 32'sd0,  32'sd0}},
    '{OP_REMOVE, 32'sd0,   1'b1, '{ST_NOT_FOUND, 6'd0, 7'd0, 1'b1, 32'sd0,  32'sd0}},
    '{OP_INSERT, INT_MIN,  1'b1, '{ST_INSERTED,  6'd0, 7'd1, 1'b0, INT_MIN, INT_MIN}},
    '{OP_INSERT, INT_MAX,  1'b1, '{ST_INSERTED,  6'd0, 7'd2, 1'b0, INT_MIN, INT_MAX}},
    '{OP_INSERT, INT_MAX,  1'b1, '{ST_DUPLICATE, 6'd0, 7'd2, 1'b0, INT_MIN, INT_MAX}},
    '{OP_INSERT, INT_MIN,  1'b1, '{ST_DUPLICATE, 6'd0, 7'd2, 1'b0, INT_MIN, INT_MAX}},
    '{OP_LOOKUP, INT_MAX,  1'b1, '{ST_PRESENT,   6'd1, 7'd2, 1'b0, INT_MIN, INT_MAX}},
    '{OP_SPARE,  INT_MIN,  1'b1, '{ST_PRESENT,   6'd0, 7'd2, 1'b0, INT_MIN, INT_MAX}},
    '{OP_SPARE,  32'sd0,   1'b1, '{ST_ABSENT,    6'd0, 7'd2, 1'b0, INT_MIN, INT_MAX}},
    '{OP_INSERT, 32'sd0,   1'b1, '{ST_INSERTED,  6'd0, 7'd3, 1'b0, INT_MIN, INT_MAX}},
    '{OP_INSERT, MINUS_1,  1'b1, '{ST_INSERTED,  6'd0, 7'd4, 1'b0, INT_MIN, INT_MAX}},
    '{OP_INSERT, 32'sd1,   1'b1, '{ST_INSERTED,  6'd0, 7'd5, 1'b0, INT_MIN, INT_MAX}},
    '{OP_LOOKUP, MINUS_1,  1'b1, '{ST_PRESENT,   6'd3, 7'd5, 1'b0, INT_MIN, INT_MAX}},
    '{OP_REMOVE, INT_MIN,  1'b1, '{ST_REMOVED,   6'd0, 7'd4, 1'b0, MINUS_1, INT_MAX}},
    '{OP_LOOKUP, 32'sd1,   1'b1, '{ST_PRESENT,   6'd3, 7'd4, 1'b0, MINUS_1, INT_MAX}},
    '{OP_REMOVE, 32'sd0,   1'b1, '{ST_REMOVED,   6'd1, 7'd3, 1'b0, MINUS_1, INT_MAX}},
    '{OP_REMOVE, 32'sd0,   1'b1, '{ST_NOT_FOUND, 6'd0, 7'd3, 1'b0, MINUS_1, INT_MAX}},
    '{OP_LOOKUP, ALT_0101, 1'b0, FROM_MODEL},
    '{OP_INSERT, ALT_1010, 1'b0, FROM_MODEL},
    '{OP_REMOVE, INT_MAX,  1'b0, FROM_MODEL},
    '{OP_REMOVE, 32'sd1,   1'b0, FROM_MODEL},
    '{OP_REMOVE, MINUS_1,  1'b0, FROM_MODEL},
    '{OP_REMOVE, ALT_1010, 1'b1, '{ST_REMOVED,   6'd0, 7'd0, 1'b1, 32'sd0,  32'sd0}},
    '{OP_LOOKUP, ALT_1010, 1'b1, '{ST_ABSENT,    6'd0, 7'd0, 1'b1, 32'sd0,  32'sd0}}
  };

  logic clk;
  logic rst;

  ist_req_if req_ch ();
  ist_rsp_if rsp_ch ();

  integer_set_table #(.CAPACITY(CAPACITY)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic signed [VALUE_W-1:0] set_members [$];
  set_result_t               pending_results [$];

  int  requests_sent;
  int  responses_checked;
  int  error_count;
  int  status_counts [7];
  bit  req_idle_on;
  bit  rsp_idle_on;
  bit  hold_pending;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one operation to the model of the set and returns its response.
  function automatic set_result_t apply_set_operation(logic [OP_W-1:0] op,
                                                      logic signed [VALUE_W-1:0] value);
    set_result_t r;
    int          idx;
    idx = -1;
    foreach (set_members[i]) begin
      if (idx < 0 && set_members[i] == value) idx = i;
    end
    r.position = '0;
    case (op)
      OP_INSERT: begin
        if (idx >= 0) r.status = ST_DUPLICATE;
        else if (set_members.size() >= CAPACITY) r.status = ST_FULL;
        else begin
          set_members.push_back(value);
          r.status = ST_INSERTED;
        end
      end
      OP_REMOVE: begin
        if (idx >= 0) begin
          set_members.delete(idx);
          r.position = POSITION_W'(idx);
          r.status   = ST_REMOVED;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (idx >= 0) begin
          r.position = POSITION_W'(idx);
          r.status   = ST_PRESENT;
        end else begin
          r.status = ST_ABSENT;
        end
      end
    endcase
    r.size     = SIZE_W'(set_members.size());
    r.is_empty = (set_members.size() == 0);
    r.smallest = '0;
    r.largest  = '0;
    foreach (set_members[i]) begin
      if (i == 0 || set_members[i] < r.smallest) r.smallest = set_members[i];
      if (i == 0 || set_members[i] > r.largest) r.largest = set_members[i];
    end
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value(int member_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < member_pct && set_members.size() > 0)
      return set_members[$urandom_range(0, set_members.size() - 1)];
    else if (roll < member_pct + 15)
      return VALUE_W'(int'($urandom_range(0, 15)) - 8);
    else if (roll < member_pct + 20) begin
      case ($urandom_range(0, 3))
        0: return INT_MIN;
        1: return INT_MAX;
        2: return INT_MIN + 1;
        default: return INT_MAX - 1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(phase_t phase);
    int roll;
    roll = $urandom_range(0, 99);
    case (phase)
      PH_FILL: begin
        if (roll < 75) return OP_INSERT;
        else if (roll < 85) return OP_LOOKUP;
        else if (roll < 95) return OP_REMOVE;
      end
      PH_DRAIN: begin
        if (roll < 70) return OP_REMOVE;
        else if (roll < 85) return OP_LOOKUP;
        else if (roll < 93) return OP_INSERT;
      end
      default: begin
        if (roll < 35) return OP_INSERT;
        else if (roll < 60) return OP_REMOVE;
        else if (roll < 92) return OP_LOOKUP;
      end
    endcase
    return OP_SPARE;
  endfunction

  // Offers one request and returns at the edge where it is accepted.
  task automatic send_request(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value,
                              bit fixed_result, set_result_t fixed);
    int          gap;
    set_result_t predicted;
    gap = req_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predicted = apply_set_operation(op, value);
    pending_results.push_back(fixed_result ? fixed : predicted);
    requests_sent++;
  endtask

  task automatic compare_field(string name, logic signed [63:0] expv,
                               logic signed [63:0] actv);
    if (actv !== expv) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      error_count++;
    end
  endtask

  // Stimulus: reset, the directed table, then random phases.
  initial begin
    phase_t phase;
    int     phase_index;
    int     phase_items;
    int     tail;
    bit     phase_done;

    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.op     = OP_INSERT;
    req_ch.value  = '0;
    req_idle_on   = 1'b1;
    rsp_idle_on   = 1'b1;
    hold_pending  = 1'b0;
    requests_sent = 0;
    error_count   = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].value,
                   directed_rows[i].fixed_result, directed_rows[i].result);
    end

    phase_index = 0;
    while (requests_sent < TOTAL_ITEMS) begin
      if (phase_index == 0) phase = PH_FILL;
      else phase = phase_t'($urandom_range(0, 2));
      req_idle_on = ($urandom_range(0, 3) != 0);
      rsp_idle_on = ($urandom_range(0, 3) != 0);
      if (phase_index == 2) begin
        // Keep requests coming back to back while responses are held off.
        hold_pending = 1'b1;
        req_idle_on  = 1'b0;
      end
      phase_items = 0;
      tail        = 0;
      phase_done  = 1'b0;
      while (!phase_done && requests_sent < TOTAL_ITEMS) begin
        logic [OP_W-1:0] op;
        op = pick_op(phase);
        send_request(op, pick_value(phase == PH_FILL ? 10 : (phase == PH_DRAIN ? 80 : 40)),
                     1'b0, FROM_MODEL);
        phase_items++;
        // A fill phase runs a few requests past full, a drain past empty.
        if ((phase == PH_FILL && set_members.size() == CAPACITY) ||
            (phase == PH_DRAIN && set_members.size() == 0))
          tail++;
        phase_done = (phase == PH_MIXED) ? (phase_items >= 60)
                                         : (tail >= 8 || phase_items >= 250);
      end
      phase_index++;
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d responses over %0d phases.",
             requests_sent, responses_checked, phase_index);
    $display("Statuses: %0d inserted, %0d duplicate, %0d full, %0d removed,",
             status_counts[0], status_counts[1], status_counts[2], status_counts[3]);
    $display("          %0d not found, %0d present, %0d absent.",
             status_counts[4], status_counts[5], status_counts[6]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Response side: random stalls, one long hold-off, and the checks.
  initial begin
    int          gap;
    set_result_t exp;

    rsp_ch.ready      = 1'b0;
    responses_checked = 0;
    foreach (status_counts[i]) status_counts[i] = 0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = rsp_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $display("%0t ns: response with no request outstanding, status %0d",
                 $time, rsp_ch.status);
        error_count++;
      end else begin
        exp = pending_results.pop_front();
        compare_field("status",   exp.status,   rsp_ch.status);
        compare_field("position", exp.position, rsp_ch.position);
        compare_field("size",     exp.size,     rsp_ch.size);
        compare_field("is_empty", exp.is_empty, rsp_ch.is_empty);
        compare_field("smallest", exp.smallest, rsp_ch.smallest);
        compare_field("largest",  exp.largest,  rsp_ch.largest);
        if (int'(exp.status) < 7) status_counts[int'(exp.status)]++;
        responses_checked++;
      end
    end
  end

  initial begin
    #25_000_000;
    $display("Timeout with %0d responses outstanding", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ integer_set_table.f @@
hdl/ist_pkg.sv
hdl/ist_req_if.sv
hdl/ist_rsp_if.sv
hdl/ist_extremes.sv
hdl/integer_set_table.sv
tb/tb_integer_set_table.sv
